// ===== hdl/kmsd_pkg.sv =====
// Shared types and constants for the key matrix scan and debounce block.
`default_nettype none

package kmsd_pkg;

  localparam int ROW_W  = 3;
  localparam int COL_W  = 17;
  localparam int CNT_W  = 8;
  localparam int ONES_W = $clog2(COL_W + 1);

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd5;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_lines;
    logic             scan_end;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0] row_state;
    logic             settled;
    logic [CNT_W-1:0] pressed_count;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/kmsd_matrix.sv =====
// Sample and debounced matrix state with the per-row update and key count.
`default_nettype none

module kmsd_matrix
  import kmsd_pkg::*;
#(
  parameter int ROW_COUNT    = 8,
  parameter int COLUMN_COUNT = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire item_t            item,
  input  wire logic [CNT_W-1:0] debounce_scans,
  output      result_t          result
);

  localparam int IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int TOT_W = $clog2(ROW_COUNT * COL_W + 1);
  localparam logic [COL_W-1:0] COL_MASK = (COLUMN_COUNT >= COL_W) ? {COL_W{1'b1}} :
                                          COL_W'((64'd1 << COLUMN_COUNT) - 64'd1);

  logic [COL_W-1:0]  sampled     [ROW_COUNT];
  logic [COL_W-1:0]  debounced   [ROW_COUNT];
  logic [ONES_W-1:0] sample_ones [ROW_COUNT];
  logic [TOT_W-1:0]  sample_total;
  logic [TOT_W-1:0]  debounced_total;
  logic [CNT_W-1:0]  countdown;

  logic [IDX_W-1:0]  ridx;
  logic              row_ok;
  logic [COL_W-1:0]  cols;
  logic [ONES_W-1:0] new_ones;
  logic              wr;
  logic [CNT_W-1:0]  reload;
  logic [CNT_W-1:0]  cd_loaded;
  logic              tick;
  logic              copy;
  logic [CNT_W-1:0]  countdown_next;
  logic [TOT_W-1:0]  sample_total_next;
  logic [TOT_W-1:0]  debounced_total_next;

  always_comb begin
    ridx      = IDX_W'(item.row_index);
    row_ok    = 32'(item.row_index) < ROW_COUNT;
    cols      = ~item.column_lines & COL_MASK;
    new_ones  = ONES_W'($countones(cols));
    wr        = row_ok && (sampled[ridx] != cols);
    reload    = (debounce_scans == '0) ? CNT_W'(1) : debounce_scans;
    cd_loaded = wr ? reload : countdown;
    tick      = item.scan_end && (cd_loaded != '0);
    countdown_next = tick ? cd_loaded - CNT_W'(1) : cd_loaded;
    copy      = tick && (countdown_next == '0);
    sample_total_next = wr ? sample_total - TOT_W'(sample_ones[ridx]) + TOT_W'(new_ones)
                           : sample_total;
    debounced_total_next = copy ? sample_total_next : debounced_total;

    if (!row_ok) begin
      result.row_state = '0;
    end else if (copy) begin
      result.row_state = cols;
    end else begin
      result.row_state = debounced[ridx];
    end
    result.settled = (countdown_next == '0);
    result.pressed_count = (32'(debounced_total_next) > 32'd255) ? {CNT_W{1'b1}} :
                           CNT_W'(debounced_total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROW_COUNT; i++) begin
        sampled[i]     <= '0;
        debounced[i]   <= '0;
        sample_ones[i] <= '0;
      end
      sample_total    <= '0;
      debounced_total <= '0;
      countdown       <= DEBOUNCE_RESET;
    end else if (step) begin
      if (wr) begin
        sampled[ridx]     <= cols;
        sample_ones[ridx] <= new_ones;
      end
      if (copy) begin
        for (int i = 0; i < ROW_COUNT; i++) begin
          debounced[i] <= (wr && (ridx == IDX_W'(i))) ? cols : sampled[i];
        end
      end
      sample_total    <= sample_total_next;
      debounced_total <= debounced_total_next;
      countdown       <= countdown_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/key_matrix_scan_debounce_top.sv =====
// Top level of the key matrix scanner with whole-matrix debounce.
//
// One row reading is taken per cycle while in_stall is low. A reading lands in an input register,
// is applied to the sample matrix, countdown and debounced matrix once the result register is
// free, and the result register holds what it produced. The sustained rate is one item per
// clock while out_stall does not block the result, set by the row update in the matrix; the key
// count is kept as running per-row totals so no wide sum is formed. debounce_scans is to be
// written by the user through cfg_valid/cfg_ready (always ready) only while idle; the block
// itself does not enforce this; a new value only changes the reload, not a running countdown.
`default_nettype none

module key_matrix_scan_debounce_top
  import kmsd_pkg::*;
#(
  parameter int ROW_COUNT    = 8,
  parameter int COLUMN_COUNT = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire logic [ROW_W-1:0] row_index,
  input  wire logic [COL_W-1:0] column_lines,
  input  wire logic             scan_end,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [COL_W-1:0] row_state,
  output      logic             settled,
  output      logic [CNT_W-1:0] pressed_count,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  logic             s1_valid;
  item_t            s1_item;
  result_t          res;
  result_t          out_res;
  logic [CNT_W-1:0] debounce_scans;
  logic             out_free;
  logic             step;

  assign out_free  = !out_valid || !out_stall;
  assign step      = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      debounce_scans <= DEBOUNCE_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (step) begin
        s1_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        debounce_scans <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.row_index    <= row_index;
      s1_item.column_lines <= column_lines;
      s1_item.scan_end     <= scan_end;
    end
    if (step) begin
      out_res <= res;
    end
  end

  kmsd_matrix #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_matrix (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .item           (s1_item),
    .debounce_scans (debounce_scans),
    .result         (res)
  );

  assign row_state     = out_res.row_state;
  assign settled       = out_res.settled;
  assign pressed_count = out_res.pressed_count;

  // a held reading always moves on once the result slot is free
  a_s1_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("pending reading did not reach the result register");

  // a transfer in always fills the input register
  a_in_capture: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("input transfer lost");

  // input side stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ===== tb/tb_key_matrix_scan_debounce_top.sv =====
// Self-checking testbench: random row scans with debounce changes against a cycle-free predictor.
`timescale 1ns / 1ps

module tb_key_matrix_scan_debounce_top
  import kmsd_pkg::*;
();

  localparam int ROWS      = 8;
  localparam int MAX_GAP   = 19;
  localparam int HOLD_LEN  = 200;
  localparam int CYCLE_CAP = 200000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ROW_W-1:0] row_index = '0;
  logic [COL_W-1:0] column_lines = '0;
  logic             scan_end = 1'b0;
  logic             out_valid;
  logic             out_stall;
  logic [COL_W-1:0] row_state;
  logic             settled;
  logic [CNT_W-1:0] pressed_count;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  logic rx_stall = 1'b0;
  logic rx_hold  = 1'b0;
  assign out_stall = rx_stall | rx_hold;

  // predictor state
  logic [COL_W-1:0] sample_mx [ROWS];
  logic [COL_W-1:0] stable_mx [ROWS];
  logic [CNT_W-1:0] countdown;
  logic [CNT_W-1:0] reload;

  item_t            pending [$];
  result_t          expected [$];
  logic [COL_W-1:0] held_lines [ROWS];

  int items_queued = 0;
  int results_done = 0;
  int err_count    = 0;
  int cycle_cnt    = 0;
  int tx_wait      = 0;
  int rx_wait      = 0;
  int hold_left    = 0;
  bit tx_burst     = 1'b0;
  bit rx_burst     = 1'b0;

  key_matrix_scan_debounce_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .row_index     (row_index),
    .column_lines  (column_lines),
    .scan_end      (scan_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_state     (row_state),
    .settled       (settled),
    .pressed_count (pressed_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic result_t predict_scan(input item_t it);
    logic [COL_W-1:0] pressed;
    int unsigned      total;
    result_t          res;
    pressed = ~it.column_lines;
    total   = 0;
    if (it.row_index < ROWS && sample_mx[it.row_index] != pressed) begin
      sample_mx[it.row_index] = pressed;
      countdown = (reload == 0) ? CNT_W'(1) : reload;
    end
    if (it.scan_end && countdown != 0) begin
      countdown = countdown - CNT_W'(1);
      if (countdown == 0)
        stable_mx = sample_mx;
    end
    for (int r = 0; r < ROWS; r++)
      total += $countones(stable_mx[r]);
    if (total > 255)
      total = 255;
    res.row_state     = (it.row_index < ROWS) ? stable_mx[it.row_index] : '0;
    res.settled       = (countdown == 0);
    res.pressed_count = CNT_W'(total);
    return res;
  endfunction

  task automatic push_item(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] l,
                           input logic e);
    pending.push_back(item_t'({r, l, e}));
    items_queued++;
  endtask

  task automatic set_debounce(input logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reload = v;
  endtask

  task automatic wait_idle();
    while (results_done != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly full scans of a slowly changing key set, with bounces, partial scans, noise and lone scan ends
  task automatic add_traffic(input int n);
    int               made;
    int               pick;
    int               len;
    int               rr;
    logic [COL_W-1:0] lines;
    made = 0;
    for (int r = 0; r < ROWS; r++)
      held_lines[r] = COL_W'($urandom | $urandom);
    while (made < n) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        if ($urandom_range(0, 3) == 0) begin
          rr = $urandom_range(0, ROWS - 1);
          held_lines[rr] = held_lines[rr] ^ (COL_W'(1) << $urandom_range(0, COL_W - 1));
        end
        rr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ROWS - 1) : ROWS;
        for (int r = 0; r < ROWS; r++) begin
          lines = held_lines[r];
          if (r == rr)
            lines = lines ^ (COL_W'(1) << $urandom_range(0, COL_W - 1));
          push_item(ROW_W'(r), lines, r == ROWS - 1);
        end
        made += ROWS;
      end else if (pick == 7) begin
        len = $urandom_range(1, ROWS - 1);
        rr  = $urandom_range(0, ROWS - 1);
        for (int k = 0; k < len; k++)
          push_item(ROW_W'((rr + k) % ROWS), held_lines[(rr + k) % ROWS],
                    $urandom_range(0, 3) == 0);
        made += len;
      end else if (pick == 8) begin
        push_item(ROW_W'($urandom_range(0, ROWS - 1)), COL_W'($urandom),
                  1'($urandom_range(0, 1)));
        made++;
      end else begin
        rr = $urandom_range(0, ROWS - 1);
        push_item(ROW_W'(rr), held_lines[rr], 1'b1);
        made++;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin : drv
    item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected.push_back(predict_scan(item_t'({row_index, column_lines, scan_end})));
      if (!(in_valid && in_stall)) begin
        if (tx_wait != 0) begin
          in_valid <= 1'b0;
          tx_wait  <= tx_wait - 1;
        end else if (pending.size() != 0) begin
          nxt = pending.pop_front();
          row_index    <= nxt.row_index;
          column_lines <= nxt.column_lines;
          scan_end     <= nxt.scan_end;
          in_valid     <= 1'b1;
          if ($urandom_range(0, 15) == 0)
            tx_burst = !tx_burst;
          tx_wait <= tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // monitor
  always @(posedge clk) begin : mon
    result_t got;
    result_t want;
    int      w;
    if (rst) begin
      rx_stall <= 1'b0;
      rx_wait  <= 0;
    end else if (out_valid && !out_stall) begin
      got = {row_state, settled, pressed_count};
      results_done <= results_done + 1;
      if (expected.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %h", $time, got);
        err_count++;
      end else begin
        want = expected.pop_front();
        check_field("row_state", 32'(want.row_state), 32'(got.row_state));
        check_field("settled", 32'(want.settled), 32'(got.settled));
        check_field("pressed_count", 32'(want.pressed_count), 32'(got.pressed_count));
      end
      if ($urandom_range(0, 15) == 0)
        rx_burst = !rx_burst;
      w = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      rx_wait  <= w;
      rx_stall <= (w != 0);
    end else if (rx_wait != 0) begin
      rx_wait  <= rx_wait - 1;
      rx_stall <= (rx_wait > 1);
    end
  end

  // long receiver hold-offs so the block backs up into its input
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst) begin
      rx_hold   <= 1'b0;
      hold_left <= 0;
    end else if (cycle_cnt == 1500 || cycle_cnt == 6000) begin
      rx_hold   <= 1'b1;
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rx_hold   <= (hold_left > 1);
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt == CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < ROWS; r++) begin
      sample_mx[r] = '0;
      stable_mx[r] = '0;
    end
    countdown = DEBOUNCE_RESET;
    reload    = DEBOUNCE_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset setting: a pressed row needs five scans to show up
    repeat (5) push_item(3'd0, '0, 1'b1);
    wait_idle();

    // zero acts as one
    set_debounce(8'd0);
    push_item(3'd7, 17'h00000, 1'b1);
    push_item(3'd3, 17'h1FFFF, 1'b1);
    push_item(3'd5, 17'h15555, 1'b0);
    push_item(3'd5, 17'h15555, 1'b1);
    push_item(3'd0, 17'h1FFFF, 1'b1);
    push_item(3'd7, 17'h1FFFE, 1'b0);
    push_item(3'd2, 17'h0FFFF, 1'b1);
    push_item(3'd6, 17'h0AAAA, 1'b0);
    push_item(3'd6, 17'h15555, 1'b0);
    push_item(3'd1, 17'h1FFFF, 1'b1);
    wait_idle();

    // longest setting: a steady row until the countdown runs out
    set_debounce(8'd255);
    push_item(3'd4, 17'h00000, 1'b1);
    repeat (256) push_item(3'd4, 17'h00000, 1'b1);
    wait_idle();

    set_debounce(8'd1);
    add_traffic(100);
    wait_idle();
    set_debounce(8'd3);
    add_traffic(130);
    wait_idle();
    set_debounce(8'd2);
    add_traffic(90);
    wait_idle();
    set_debounce(DEBOUNCE_RESET);
    add_traffic(60);
    wait_idle();

    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== key_matrix_scan_debounce_top.f =====
hdl/kmsd_pkg.sv
hdl/kmsd_matrix.sv
hdl/key_matrix_scan_debounce_top.sv
tb/tb_key_matrix_scan_debounce_top.sv
